// ===== design/esc_dfs_pkg.sv =====
// Shared types and constants for the ESC digital frame serializer.
// Has no dependencies. The serializer top level imports it.
package esc_dfs_pkg;

  localparam int FRAME_BITS = 16;
  localparam int SLOTS_PER_BIT = 3;
  localparam int BIT_SLOTS = FRAME_BITS * SLOTS_PER_BIT;
  localparam int VALUE_W = 10;
  localparam int CSUM_W = 4;
  localparam int THROTTLE_W = 16;
  localparam int MOTOR_ID_W = 2;
  localparam int VISIBLE_LINES = 4;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic {
    REQ_SET  = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  // Position of a slot inside one frame bit.
  typedef logic [1:0] phase_t;
  localparam phase_t PH_HIGH = 2'd0;
  localparam phase_t PH_DATA = 2'd1;
  localparam phase_t PH_LOW  = 2'd2;

endpackage

// ===== design/esc_digital_frame_serializer_top.sv =====
// Top level of the ESC digital frame serializer: throttle scaling, frame build
// and the repeating per-line slot waveform. Depends on esc_dfs_pkg.
//
// The block takes one item per clock unless in_stall holds it: a set item
// scales a throttle into a new pending frame for one motor, a tick item
// produces one output slot for all lines. Items pass an input register and
// then a result register, and a stalled result register can hold a tick in
// the input register. One item per cycle holds, stalls apart, because the 16x10
// scaling multiplier and its divide-by-65535 correction are combinational. The
// input side keeps accepting while a result waits, and only a tick that cannot
// move into a full, stalled result register holds it. Pending frames become
// active at the first slot of each frame, and a frame is 48 bit slots followed
// by GAP_SLOTS low slots, looping forever.
module esc_digital_frame_serializer_top
  import esc_dfs_pkg::*;
#(
  parameter int NUM_MOTORS = 4,
  parameter int GAP_SLOTS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [VALUE_W-1:0]    cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [MOTOR_ID_W-1:0] in_motor_id,
  input  logic [THROTTLE_W-1:0] in_throttle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_line_levels,
  output logic                  out_frame_start
);

  localparam int TOTAL_SLOTS = BIT_SLOTS + GAP_SLOTS;
  localparam int SLOT_W = $clog2(TOTAL_SLOTS);
  localparam int PROD_W = THROTTLE_W + VALUE_W;
  localparam int REM_W = PROD_W + 2;

  // Configuration.
  value_t max_output_r;

  // Input register.
  logic                  s1_valid_r;
  logic                  s1_req_r;
  logic [MOTOR_ID_W-1:0] s1_id_r;
  logic [THROTTLE_W-1:0] s1_thr_r;

  // Frame store.
  frame_t pending_r [NUM_MOTORS];
  frame_t active_r  [NUM_MOTORS];

  // Slot position.
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  phase_t            phase_r, phase_nxt;
  logic [3:0]        bit_r, bit_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] levels_r;
  logic       start_r;

  logic in_accept;
  logic s1_is_tick;
  logic s1_go;
  logic tick_fire;
  logic set_fire;

  assign s1_is_tick = (s1_req_r == REQ_TICK);
  assign s1_go      = !(s1_is_tick && out_valid_r && out_stall);
  assign in_stall   = s1_valid_r && !s1_go;
  assign in_accept  = in_valid && !in_stall;
  assign tick_fire  = s1_valid_r && s1_is_tick && s1_go;
  assign set_fire   = s1_valid_r && !s1_is_tick;

  // Scaling: value = floor(throttle * max_output / 65535). The estimate
  // (p + p/65536) / 65536 is never high and at most one low, so one compare
  // against the remainder finishes the quotient.
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     est_sum;
  logic [VALUE_W:0]    quot_est;
  logic [REM_W-1:0]    rem;
  logic [VALUE_W:0]    quot;
  value_t              value;
  logic [CSUM_W-1:0]   csum;
  frame_t              new_frame;

  assign prod     = PROD_W'(s1_thr_r) * PROD_W'(max_output_r);
  assign est_sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(prod[PROD_W-1:THROTTLE_W]);
  assign quot_est = est_sum[PROD_W:THROTTLE_W];
  assign rem      = REM_W'(prod) - (REM_W'(quot_est) << THROTTLE_W) + REM_W'(quot_est);
  assign quot     = (rem >= REM_W'(65535)) ? quot_est + (VALUE_W+1)'(1) : quot_est;
  assign value    = quot[VALUE_W-1:0];
  assign csum     = value[9:6] ^ value[5:2] ^ {value[1:0], 2'b00};
  assign new_frame = {value, 2'b00, csum};

  // Slot counters: the bit and phase counters stand in for slot / 3 and slot % 3.
  logic frame_start;
  logic in_bits;

  assign frame_start = (slot_r == '0);
  assign in_bits     = (slot_r < SLOT_W'(BIT_SLOTS));

  always_comb begin
    slot_nxt  = slot_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    if (tick_fire) begin
      if (slot_r == SLOT_W'(TOTAL_SLOTS - 1)) begin
        slot_nxt  = '0;
        phase_nxt = PH_HIGH;
        bit_nxt   = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
        if (phase_r == PH_LOW) begin
          phase_nxt = PH_HIGH;
          bit_nxt   = bit_r + 4'd1;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
    end
  end

  // Line levels; the first slot of a frame is always a high phase, so reading
  // the active frame before it is refreshed gives the same levels.
  logic [3:0] levels;
  logic [3:0] bit_sel;

  assign bit_sel = 4'(FRAME_BITS - 1) - bit_r;

  genvar g;
  for (g = 0; g < VISIBLE_LINES; g++) begin : g_line
    if (g < NUM_MOTORS) begin : g_on
      always_comb begin
        levels[g] = 1'b0;
        if (in_bits) begin
          case (phase_r)
            PH_HIGH: levels[g] = 1'b1;
            PH_DATA: levels[g] = active_r[g][bit_sel];
            default: levels[g] = 1'b0;
          endcase
        end
      end
    end else begin : g_off
      assign levels[g] = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_output_r <= '1;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_r       <= '0;
      phase_r      <= PH_HIGH;
      bit_r        <= '0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        pending_r[m] <= '0;
        active_r[m]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        max_output_r <= cfg_wr_data;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      // A set for a motor beyond the configured count is dropped.
      for (int m = 0; m < NUM_MOTORS; m++) begin
        if (set_fire && ({1'b0, s1_id_r} == 3'(m))) begin
          pending_r[m] <= new_frame;
        end
        if (tick_fire && frame_start) begin
          active_r[m] <= pending_r[m];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= in_req_type;
      s1_id_r  <= in_motor_id;
      s1_thr_r <= in_throttle;
    end
    if (tick_fire) begin
      levels_r <= levels;
      start_r  <= frame_start;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_levels = levels_r;
  assign out_frame_start = start_r;

endmodule
